FILE: design/cble_pkg.sv
package cble_pkg;

    // Field and register widths
    localparam int IDX_W      = 2;
    localparam int BIT_NS_W   = 24;
    localparam int LEN_W      = 7;
    localparam int PCT_W      = 11;
    localparam int SCALED_W   = 17;
    localparam int BUSY_W     = 32;
    localparam int CTRL_W     = 7;
    localparam int DBITS_W    = 10;
    localparam int FT_W       = 35;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_NOMINAL_BIT_NS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DATA_BIT_NS    = 2'd1;

    // Item kinds
    localparam logic MODE_FRAME      = 1'b0;
    localparam logic MODE_WINDOW_END = 1'b1;

    // Frame geometry
    localparam logic [CTRL_W-1:0] CTRL_BITS_EXT = 7'd67;
    localparam logic [CTRL_W-1:0] CTRL_BITS_STD = 7'd47;
    localparam logic [LEN_W-1:0]  MAX_PAYLOAD   = 7'd64;

    // busy / 2500000 with 2500000 = 2^5 * 78125:
    // drop 5 bits, then multiply by ceil(2^44 / 78125) and keep the top bits.
    // The rounding error times the largest 27-bit operand stays below 2^44.
    localparam int                PCT_PRE_SHIFT   = 5;
    localparam int                PCT_RECIP_W     = 28;
    localparam logic [27:0]       PCT_RECIP       = 28'd225179982;
    localparam int                PCT_RECIP_SHIFT = 44;
    localparam int                PCT_PROD_W      = BUSY_W - PCT_PRE_SHIFT + PCT_RECIP_W;
    localparam logic [PCT_W-1:0]  PCT_MAX         = 11'd1717;

    // pct * 4095 / 100 as pct * ceil(4095 * 2^18 / 100) >> 18, exact for 11-bit pct
    localparam int                SCALE_RECIP_W   = 24;
    localparam logic [23:0]       SCALE_RECIP     = 24'd10734797;
    localparam int                SCALE_SHIFT     = 18;
    localparam int                SCALE_PROD_W    = PCT_W + SCALE_RECIP_W;
    localparam int unsigned       SCALE_FULL      = 4095;

endpackage

FILE: design/cble_in_if.sv
interface cble_in_if import cble_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic             extended_id;
    logic             bitrate_switch;
    logic [LEN_W-1:0] payload_len;

    modport source (output valid, mode, extended_id, bitrate_switch, payload_len,
                    input ready);
    modport sink   (input valid, mode, extended_id, bitrate_switch, payload_len,
                    output ready);
endinterface

FILE: design/cble_out_if.sv
interface cble_out_if import cble_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PCT_W-1:0]    load_percent;
    logic [SCALED_W-1:0] load_scaled;

    modport source (output valid, load_percent, load_scaled, input ready);
    modport sink   (input valid, load_percent, load_scaled, output ready);
endinterface

FILE: design/cble_cfg_if.sv
interface cble_cfg_if import cble_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    index;
    logic [BIT_NS_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/can_bus_load_estimator.sv
// CAN bus load estimator, one channel.
//
// i_in carries one word per bus event: a frame seen on the bus (mode 0, with
// extended_id, bitrate_switch and payload_len) or the end of a 250 ms window
// (mode 1). Every input word yields exactly one o_out word holding the load
// of the last full window, in percent and scaled to 4095 per 100 percent.
// i_cfg writes the nominal (index 0) and data (index 1) bit times in ns; it
// is always ready. Write it only while no word is in flight; not enforced.
//
// The word passes four registers: input register, frame-time multipliers,
// accumulator / percent multiplier, scaling multiplier into the output
// register. One word is accepted per cycle while i_in.ready is high. When
// o_out stalls, empty stages ahead of it keep filling, so i_in.ready drops
// only once all four stages hold a word.
//
// Reset (i_rst_n low, synchronous) empties the pipeline and clears the bit
// times, the busy-time accumulator and the held load percent.
module can_bus_load_estimator import cble_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cble_in_if.sink    i_in,
    cble_out_if.source o_out,
    cble_cfg_if.sink   i_cfg
);

    // Configuration registers
    logic [BIT_NS_W-1:0] r_nominal_bit_ns;
    logic [BIT_NS_W-1:0] r_data_bit_ns;

    // Stage 1: input register
    logic             r_s1_valid;
    logic             r_s1_mode;
    logic             r_s1_ext;
    logic             r_s1_brs;
    logic [LEN_W-1:0] r_s1_len;

    // Stage 2: frame time
    logic            r_s2_valid;
    logic            r_s2_mode;
    logic [FT_W-1:0] r_s2_frame_ns;

    // Stage 3: accumulator and held load
    logic              r_s3_valid;
    logic [PCT_W-1:0]  r_s3_pct;
    logic [BUSY_W-1:0] r_busy_time_ns;
    logic [PCT_W-1:0]  r_last_load_percent;
    logic [BUSY_W-1:0] n_busy_time_ns;
    logic [PCT_W-1:0]  n_last_load_percent;

    // Stage 4: output register
    logic                r_out_valid;
    logic [PCT_W-1:0]    r_out_pct;
    logic [SCALED_W-1:0] r_out_scaled;

    // Per-stage advance: a stage takes a new word when it is empty or drains
    logic adv1, adv2, adv3, adv4;
    logic fire1, fire2, fire3;

    assign adv4  = !r_out_valid || o_out.ready;
    assign adv3  = !r_s3_valid || adv4;
    assign adv2  = !r_s2_valid || adv3;
    assign adv1  = !r_s1_valid || adv2;
    assign fire1 = r_s1_valid && adv2;
    assign fire2 = r_s2_valid && adv3;
    assign fire3 = r_s3_valid && adv4;

    assign i_in.ready  = adv1;
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal_bit_ns <= '0;
            r_data_bit_ns    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_NOMINAL_BIT_NS: r_nominal_bit_ns <= i_cfg.data;
                CFG_DATA_BIT_NS:    r_data_bit_ns    <= i_cfg.data;
                default:            ;
            endcase
        end
    end

    // Valid bits of all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv1) r_s1_valid  <= i_in.valid;
            if (adv2) r_s2_valid  <= r_s1_valid;
            if (adv3) r_s3_valid  <= r_s2_valid;
            if (adv4) r_out_valid <= r_s3_valid;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && adv1) begin
            r_s1_mode <= i_in.mode;
            r_s1_ext  <= i_in.extended_id;
            r_s1_brs  <= i_in.bitrate_switch;
            r_s1_len  <= i_in.payload_len;
        end
    end

    // Frame time: control bits at nominal rate, data bits at nominal or data rate
    logic [LEN_W-1:0]   len_clamped;
    logic [DBITS_W-1:0] payload_bits;
    logic [CTRL_W-1:0]  ctrl_bits;
    logic [DBITS_W-1:0] nom_bits;
    logic [FT_W-2:0]    nom_ns;
    logic [FT_W-2:0]    dat_ns;
    logic [FT_W-1:0]    frame_ns;

    always_comb begin
        len_clamped  = (r_s1_len > MAX_PAYLOAD) ? MAX_PAYLOAD : r_s1_len;
        payload_bits = {len_clamped, 3'b000};
        ctrl_bits    = r_s1_ext ? CTRL_BITS_EXT : CTRL_BITS_STD;
        nom_bits     = r_s1_brs ? {3'b000, ctrl_bits}
                                : ({3'b000, ctrl_bits} + payload_bits);
        nom_ns       = (FT_W-1)'(nom_bits) * (FT_W-1)'(r_nominal_bit_ns);
        dat_ns       = r_s1_brs ? ((FT_W-1)'(payload_bits) * (FT_W-1)'(r_data_bit_ns))
                                : '0;
        frame_ns     = {1'b0, nom_ns} + {1'b0, dat_ns};
    end

    always_ff @(posedge i_clk) begin
        if (fire1) begin
            r_s2_mode     <= r_s1_mode;
            r_s2_frame_ns <= frame_ns;
        end
    end

    // Saturating accumulate on a frame; percent and clear on a window end
    logic [FT_W-1:0]       acc_sum;
    logic [PCT_PROD_W-1:0] pct_prod;

    always_comb begin
        acc_sum  = {3'b000, r_busy_time_ns} + r_s2_frame_ns;
        pct_prod = PCT_PROD_W'(r_busy_time_ns[BUSY_W-1:PCT_PRE_SHIFT])
                   * PCT_PROD_W'(PCT_RECIP);
        n_busy_time_ns      = r_busy_time_ns;
        n_last_load_percent = r_last_load_percent;
        if (fire2) begin
            if (r_s2_mode == MODE_WINDOW_END) begin
                n_last_load_percent = pct_prod[PCT_RECIP_SHIFT +: PCT_W];
                n_busy_time_ns      = '0;
            end else if (acc_sum[FT_W-1:BUSY_W] != '0) begin
                n_busy_time_ns = '1;
            end else begin
                n_busy_time_ns = acc_sum[BUSY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_time_ns      <= '0;
            r_last_load_percent <= '0;
        end else begin
            r_busy_time_ns      <= n_busy_time_ns;
            r_last_load_percent <= n_last_load_percent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire2) r_s3_pct <= n_last_load_percent;
    end

    // Scaling into the output register
    logic [SCALE_PROD_W-1:0] scale_prod;

    assign scale_prod = SCALE_PROD_W'(r_s3_pct) * SCALE_PROD_W'(SCALE_RECIP);

    always_ff @(posedge i_clk) begin
        if (fire3) begin
            r_out_pct    <= r_s3_pct;
            r_out_scaled <= scale_prod[SCALE_SHIFT +: SCALED_W];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.load_percent = r_out_pct;
    assign o_out.load_scaled  = r_out_scaled;

    // Checks
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.load_percent <= PCT_MAX)
        else $error("load percent above full-window maximum");

    a_scaled_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> 32'(o_out.load_scaled) ==
            (32'(o_out.load_percent) * SCALE_FULL) / 32'd100)
        else $error("scaled load does not match percent");

    a_window_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire2 && r_s2_mode == MODE_WINDOW_END |=> r_busy_time_ns == '0)
        else $error("busy time not cleared at window end");

    a_frame_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire2 && r_s2_mode == MODE_FRAME |=> r_busy_time_ns >= $past(r_busy_time_ns))
        else $error("busy time decreased on a frame");

    a_load_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fire2 && r_s2_mode == MODE_WINDOW_END) |=> $stable(r_last_load_percent))
        else $error("held load changed outside a window end");

endmodule

FILE: verif/can_bus_load_estimator_tb.sv
module can_bus_load_estimator_tb import cble_pkg::*; ();

    localparam int unsigned NS_PER_PERCENT = 250000000 / 100;
    localparam int unsigned IDLE_PCT       = 36;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_SLACK    = 6;
    localparam int          MAX_REPORTS    = 10;
    localparam int          PHASE_ITEMS    = 250;
    localparam int          NUM_PHASES     = 8;
    localparam int          RX_HOLD_CYCLES = 120;

    // indexes past the last register, writes there must be dropped
    localparam logic [IDX_W-1:0]    CFG_SPARE_2 = 2'd2;
    localparam logic [IDX_W-1:0]    CFG_SPARE_3 = 2'd3;
    localparam logic [BIT_NS_W-1:0] BIT_NS_MAX  = '1;

    typedef struct packed {
        logic             mode;
        logic             ext;
        logic             brs;
        logic [LEN_W-1:0] len;
    } t_bus_word;

    localparam int WORD_W = $bits(t_bus_word);

    typedef struct packed {
        logic [PCT_W-1:0]    pct;
        logic [SCALED_W-1:0] scaled;
    } t_load_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cble_in_if  in_bus();
    cble_out_if out_bus();
    cble_cfg_if cfg_bus();

    can_bus_load_estimator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // load predictor state
    logic [BIT_NS_W-1:0] nominal_ns;
    logic [BIT_NS_W-1:0] fast_ns;
    logic [BUSY_W-1:0]   busy_ns;
    logic [PCT_W-1:0]    held_pct;
    t_load_word          load_expect_q[$];

    int err_count    = 0;
    int quiet_cycles = 0;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    int rx_hold_req  = 0;
    int rx_hold_left = 0;

    always #5 i_clk = ~i_clk;

    function automatic void log_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    // bus time of one frame, full width before the saturating add
    function automatic logic [63:0] frame_busy_ns(logic ext, logic brs,
                                                  logic [LEN_W-1:0] len);
        logic [63:0] ctrl_bits;
        logic [63:0] payload_bits;
        ctrl_bits    = ext ? 64'(CTRL_BITS_EXT) : 64'(CTRL_BITS_STD);
        payload_bits = (len > MAX_PAYLOAD) ? 64'(MAX_PAYLOAD) * 8 : 64'(len) * 8;
        if (brs) begin
            return ctrl_bits * 64'(nominal_ns) + payload_bits * 64'(fast_ns);
        end
        return (ctrl_bits + payload_bits) * 64'(nominal_ns);
    endfunction

    // update busy time / held load for one accepted word, queue its result
    function automatic void account_word(t_bus_word w);
        logic [63:0] sum;
        t_load_word  res;
        if (w.mode == MODE_WINDOW_END) begin
            held_pct = PCT_W'(busy_ns / NS_PER_PERCENT);
            busy_ns  = '0;
        end else begin
            sum     = 64'(busy_ns) + frame_busy_ns(w.ext, w.brs, w.len);
            busy_ns = (sum > 64'({BUSY_W{1'b1}})) ? '1 : BUSY_W'(sum);
        end
        res.pct    = held_pct;
        res.scaled = SCALED_W'((32'(held_pct) * SCALE_FULL) / 100);
        load_expect_q.push_back(res);
    endfunction

    function automatic t_bus_word mk_word(logic mode, logic ext, logic brs,
                                          logic [LEN_W-1:0] len);
        t_bus_word w;
        w.mode = mode;
        w.ext  = ext;
        w.brs  = brs;
        w.len  = len;
        return w;
    endfunction

    function automatic t_bus_word random_frame();
        logic [LEN_W-1:0] len;
        // mostly legal lengths, now and then one that gets clamped
        if ($urandom_range(9) == 0) begin
            len = LEN_W'($urandom_range(127, 65));
        end else begin
            len = LEN_W'($urandom_range(64));
        end
        return mk_word(MODE_FRAME, 1'($urandom), 1'($urandom), len);
    endfunction

    // window end with junk in the fields it ignores
    function automatic t_bus_word window_word();
        return mk_word(MODE_WINDOW_END, 1'($urandom), 1'($urandom), LEN_W'($urandom));
    endfunction

    // all tasks below enter and leave right after a falling edge
    task automatic send_word(t_bus_word w);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid          <= 1'b1;
        in_bus.mode           <= w.mode;
        in_bus.extended_id    <= w.ext;
        in_bus.bitrate_switch <= w.brs;
        in_bus.payload_len    <= w.len;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        account_word(w);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [BIT_NS_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        if (idx == CFG_NOMINAL_BIT_NS) begin
            nominal_ns = value;
        end else if (idx == CFG_DATA_BIT_NS) begin
            fast_ns = value;
        end
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop sending and wait for every pending result
    task automatic drain();
        in_bus.valid <= 1'b0;
        while (load_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic set_bit_times(logic [BIT_NS_W-1:0] nom, logic [BIT_NS_W-1:0] dat);
        write_reg(CFG_NOMINAL_BIT_NS, nom);
        write_reg(CFG_DATA_BIT_NS, dat);
    endtask

    // bit-time profiles: realistic, slow, anything
    task automatic pick_bit_times(int profile);
        case (profile)
            0: begin
                set_bit_times(BIT_NS_W'($urandom_range(8000, 1000)),
                              BIT_NS_W'($urandom_range(2000, 100)));
            end
            1: begin
                set_bit_times(BIT_NS_W'($urandom_range(200000)),
                              BIT_NS_W'($urandom_range(200000)));
            end
            default: begin
                set_bit_times(BIT_NS_W'($urandom), BIT_NS_W'($urandom));
            end
        endcase
    endtask

    // bit times still zero after reset: nothing accumulates
    task automatic test_reset_defaults();
        send_word(mk_word(MODE_FRAME, 1'b1, 1'b1, LEN_W'(64)));
        send_word(mk_word(MODE_WINDOW_END, 1'b0, 1'b0, '0));
        drain();
    endtask

    // every frame shape, clamped lengths, ignored fields on window end
    task automatic test_frame_shapes();
        set_bit_times(BIT_NS_W'(20000), BIT_NS_W'(5000));
        send_word(mk_word(MODE_FRAME, 1'b0, 1'b0, LEN_W'(0)));
        send_word(mk_word(MODE_FRAME, 1'b1, 1'b0, LEN_W'(0)));
        send_word(mk_word(MODE_FRAME, 1'b0, 1'b1, LEN_W'(64)));
        send_word(mk_word(MODE_FRAME, 1'b1, 1'b1, LEN_W'(64)));
        send_word(mk_word(MODE_FRAME, 1'b0, 1'b0, LEN_W'(65)));
        send_word(mk_word(MODE_FRAME, 1'b1, 1'b1, LEN_W'(127)));
        send_word(mk_word(MODE_WINDOW_END, 1'b1, 1'b1, LEN_W'(127)));
        send_word(mk_word(MODE_FRAME, 1'b0, 1'b0, LEN_W'(0)));
        send_word(mk_word(MODE_WINDOW_END, 1'b0, 1'b1, LEN_W'(64)));
        send_word(mk_word(MODE_WINDOW_END, 1'b1, 1'b0, LEN_W'(1)));
        drain();
    endtask

    // writes past the last register must leave the bit times alone
    task automatic test_unknown_index();
        write_reg(CFG_SPARE_2, BIT_NS_MAX);
        write_reg(CFG_SPARE_3, BIT_NS_MAX);
        send_word(mk_word(MODE_FRAME, 1'b1, 1'b0, LEN_W'(64)));
        send_word(mk_word(MODE_WINDOW_END, 1'b0, 1'b0, '0));
        drain();
    endtask

    // largest bit times: accumulator pins at all ones, load at its top
    task automatic test_saturation();
        set_bit_times(BIT_NS_MAX, BIT_NS_MAX);
        send_word(mk_word(MODE_FRAME, 1'b1, 1'b1, LEN_W'(127)));
        send_word(mk_word(MODE_FRAME, 1'b0, 1'b0, LEN_W'(64)));
        send_word(mk_word(MODE_WINDOW_END, 1'b0, 1'b0, '0));
        send_word(mk_word(MODE_FRAME, 1'b0, 1'b1, LEN_W'(0)));
        drain();
        // zero nominal: only switched data bits count
        write_reg(CFG_NOMINAL_BIT_NS, '0);
        send_word(mk_word(MODE_FRAME, 1'b1, 1'b0, LEN_W'(64)));
        send_word(mk_word(MODE_FRAME, 1'b0, 1'b1, LEN_W'(64)));
        send_word(mk_word(MODE_WINDOW_END, 1'b1, 1'b1, LEN_W'(127)));
        drain();
    endtask

    // receiver holds off while the sender keeps going, then sender waits
    task automatic test_output_stall();
        pick_bit_times(0);
        tx_idle_on  = 1'b0;
        rx_hold_req = RX_HOLD_CYCLES;
        repeat (30) send_word(random_frame());
        send_word(window_word());
        drain();
        repeat (10) send_word(random_frame());
        send_word(window_word());
        drain();
        tx_idle_on = 1'b1;
    endtask

    // mostly whole windows of random frames, some raw noise words
    task automatic run_random_phase(int n_items);
        int sent;
        int frames;
        t_bus_word w;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                frames = $urandom_range(40);
                repeat (frames) send_word(random_frame());
                send_word(window_word());
                sent += frames + 1;
            end else begin
                repeat ($urandom_range(5, 1)) begin
                    w = t_bus_word'(WORD_W'($urandom));
                    send_word(w);
                    sent++;
                end
            end
        end
        drain();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 6) begin
                set_bit_times('0, BIT_NS_MAX);
            end else if (phase == 7) begin
                set_bit_times(BIT_NS_MAX, BIT_NS_MAX);
            end else begin
                pick_bit_times(phase % 3);
            end
            // one phase with both sides running flat out
            tx_idle_on = (phase != 4);
            rx_idle_on = (phase != 4);
            run_random_phase(PHASE_ITEMS);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // result receiver: random stalls plus an occasional long hold
    always @(negedge i_clk) begin
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_bus.ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_load_word want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (load_expect_q.size() == 0) begin
                log_mismatch($sformatf("unexpected word pct=%0d scaled=%0d",
                                       out_bus.load_percent, out_bus.load_scaled));
            end else begin
                want = load_expect_q.pop_front();
                if (out_bus.load_percent !== want.pct) begin
                    log_mismatch($sformatf("load_percent exp=%0d got=%0d",
                                           want.pct, out_bus.load_percent));
                end
                if (out_bus.load_scaled !== want.scaled) begin
                    log_mismatch($sformatf("load_scaled exp=%0d got=%0d",
                                           want.scaled, out_bus.load_scaled));
                end
            end
        end
    end

    // watchdog: too long without any handshake
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        in_bus.valid          = 1'b0;
        in_bus.mode           = MODE_FRAME;
        in_bus.extended_id    = 1'b0;
        in_bus.bitrate_switch = 1'b0;
        in_bus.payload_len    = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = CFG_NOMINAL_BIT_NS;
        cfg_bus.data          = '0;
        out_bus.ready         = 1'b0;
        nominal_ns            = '0;
        fast_ns               = '0;
        busy_ns               = '0;
        held_pct              = '0;
        i_rst_n               = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_frame_shapes();
        test_unknown_index();
        test_saturation();
        test_output_stall();
        test_random();

        drain();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (load_expect_q.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", load_expect_q.size()));
        end
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
